// File: hdl/icd_pkg.sv
// icd_pkg: shared types, constants and the pin word builder for the input
// confirm debouncer
// no dependencies
package icd_pkg;

    // bank sizes and derived input count
    localparam int BANK_LOW_INPUTS  = 8;
    localparam int BANK_HIGH_INPUTS = 8;
    localparam int NUM_SLOTS        = 16;
    localparam int BANK_W           = 8;

    localparam int LOW_EFF   = (BANK_LOW_INPUTS > NUM_SLOTS) ? NUM_SLOTS : BANK_LOW_INPUTS;
    localparam int HIGH_EFF  = (BANK_HIGH_INPUTS > NUM_SLOTS) ? NUM_SLOTS : BANK_HIGH_INPUTS;
    localparam int NUM_INPUTS = (LOW_EFF + HIGH_EFF > NUM_SLOTS) ? NUM_SLOTS
                                                                 : LOW_EFF + HIGH_EFF;

    // register widths and reset values
    localparam int CONFIRM_W = 16;
    localparam int INC_W     = 10;
    localparam int TIMER_W   = 17;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CONFIRM_W-1:0] CONFIRM_TIME_RST = 16'd60;
    localparam logic [INC_W-1:0]     TICK_INC_RST     = 10'd1;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_CONFIRM_TIME = 1'b0,
        REG_TICK_INC     = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [CONFIRM_W-1:0] confirm_time;
        logic [INC_W-1:0]     tick_inc;
    } t_cfg;

    // low bank reversed into the bottom inputs, high bank above it in order;
    // bank bits beyond the 8-bit field read as zero
    function automatic logic [NUM_SLOTS-1:0] build_pins(
        input logic [BANK_W-1:0] lo,
        input logic [BANK_W-1:0] hi
    );
        logic [NUM_SLOTS-1:0] pins;
        pins = '0;
        for (int b = 0; b < LOW_EFF; b++) begin
            if (b < BANK_W) begin
                pins[LOW_EFF-1-b] = lo[b];
            end
        end
        for (int b = 0; b < HIGH_EFF; b++) begin
            if ((b < BANK_W) && (LOW_EFF + b < NUM_SLOTS)) begin
                pins[LOW_EFF+b] = hi[b];
            end
        end
        return pins;
    endfunction

endpackage

// File: hdl/icd_cfg_regs.sv
// icd_cfg_regs: apb register file holding confirm time and tick increment
// depends on icd_pkg
module icd_cfg_regs
    import icd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready,
    output t_cfg              o_cfg
);

    logic [CONFIRM_W-1:0] r_confirm_time;
    logic [INC_W-1:0]     r_tick_inc;
    t_reg_idx             w_idx;
    logic                 w_wr;

    assign w_idx    = t_reg_idx'(i_paddr[2]);
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_time <= CONFIRM_TIME_RST;
            r_tick_inc     <= TICK_INC_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CONFIRM_TIME: r_confirm_time <= i_pwdata[CONFIRM_W-1:0];
                REG_TICK_INC:     r_tick_inc     <= i_pwdata[INC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CONFIRM_TIME: o_prdata = {{(APB_DW-CONFIRM_W){1'b0}}, r_confirm_time};
            REG_TICK_INC:     o_prdata = {{(APB_DW-INC_W){1'b0}}, r_tick_inc};
            default:          o_prdata = '0;
        endcase
    end

    assign o_cfg.confirm_time = r_confirm_time;
    assign o_cfg.tick_inc     = r_tick_inc;

endmodule

// File: hdl/icd_lane.sv
// icd_lane: tolerance timer, sampled level and confirmed level of one input
// depends on icd_pkg
module icd_lane
    import icd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_pin,
    input  t_cfg i_cfg,
    output logic o_confirmed
);

    logic [TIMER_W-1:0] r_timer, n_timer, w_timer;
    logic               r_idle, n_idle, w_idle;
    logic               r_samp, n_samp, w_samp;
    logic               r_conf, n_conf;
    logic [TIMER_W-1:0] w_limit;

    assign w_limit = {{(TIMER_W-CONFIRM_W){1'b0}}, i_cfg.confirm_time};

    always_comb begin
        w_idle  = r_idle;
        w_timer = r_timer;
        w_samp  = r_samp;
        // start on a change, else advance a running timer
        if (r_idle) begin
            if (i_pin != r_conf) begin
                w_timer = '0;
                w_idle  = 1'b0;
                w_samp  = i_pin;
            end
        end else if (r_timer < w_limit) begin
            w_timer = r_timer + {{(TIMER_W-INC_W){1'b0}}, i_cfg.tick_inc};
        end
        n_idle  = w_idle;
        n_timer = w_timer;
        n_samp  = w_samp;
        n_conf  = r_conf;
        // confirm or drop once the limit is reached
        if (!w_idle && (w_timer >= w_limit)) begin
            if (w_samp == i_pin) begin
                n_conf = i_pin;
            end
            n_timer = '0;
            n_idle  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_idle  <= 1'b1;
            r_samp  <= 1'b0;
            r_conf  <= 1'b0;
        end else if (i_en) begin
            r_timer <= n_timer;
            r_idle  <= n_idle;
            r_samp  <= n_samp;
            r_conf  <= n_conf;
        end
    end

    assign o_confirmed = r_conf;

    a_idle_timer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idle |-> (r_timer == '0))
        else $error("idle lane with running timer");

    a_conf_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_conf))
        else $error("confirmed level moved without a tick");

    a_conf_change_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_conf) |-> r_idle)
        else $error("confirmed level changed while timer still running");

endmodule

// File: hdl/input_confirm_debouncer.sv
// input_confirm_debouncer: an accepted word is held in the input register,
// then its result word in the lane registers on the master side; one word
// per cycle unless the master side stalls, all sixteen lanes in one pass
// i_rst_n is synchronous, active low: confirm time 60, increment 1, all
// timers idle at zero, sampled and confirmed levels zero, no word held
// depends on icd_pkg, icd_cfg_regs, icd_lane
module input_confirm_debouncer
    import icd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave side
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [15:0]       i_s_axis_tdata,   // [7:0] raw_bank_low, [15:8] raw_bank_high
    // master side
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [15:0]       o_m_axis_tdata,   // [15:0] confirmed_inputs
    // configuration
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    output logic [APB_DW-1:0] o_prdata,
    output logic              o_pready
);

    t_cfg                 w_cfg;
    logic                 r_in_valid;
    logic [BANK_W-1:0]    r_bank_lo;
    logic [BANK_W-1:0]    r_bank_hi;
    logic                 r_out_valid;
    logic                 w_process;
    logic [NUM_SLOTS-1:0] w_pins;
    logic [NUM_SLOTS-1:0] w_confirmed;

    icd_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    // the held word moves into the lanes when the result slot is free or
    // being emptied in this cycle
    assign w_process       = r_in_valid & (~r_out_valid | i_m_axis_tready);
    assign o_s_axis_tready = ~r_in_valid | w_process;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_bank_lo <= i_s_axis_tdata[7:0];
            r_bank_hi <= i_s_axis_tdata[15:8];
        end
    end

    // pin word: low bank reversed, high bank above it
    assign w_pins = build_pins(r_bank_lo, r_bank_hi);

    // one lane per used input; the confirmed levels are the result register
    for (genvar gi = 0; gi < NUM_SLOTS; gi++) begin : g_lane
        if (gi < NUM_INPUTS) begin : g_used
            icd_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_en        (w_process),
                .i_pin       (w_pins[gi]),
                .i_cfg       (w_cfg),
                .o_confirmed (w_confirmed[gi])
            );
        end else begin : g_unused
            assign w_confirmed[gi] = 1'b0;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_process) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = w_confirmed;

    a_empty_input_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_s_axis_tready)
        else $error("input stage empty but not ready");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_process |=> $stable(w_confirmed))
        else $error("confirmed word changed without a processed word");

    a_process_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_process |=> o_m_axis_tvalid)
        else $error("processed word produced no result");

endmodule
